// ----- rtl/core/akgf_pkg.sv -----
// ----------------------------------------------------------------------------
// akgf_pkg
// Types, register indexes, reset values and saturation helper for the
// angle/gyro Kalman filter.
// ----------------------------------------------------------------------------
package akgf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd3;

    localparam logic [CFG_VAL_W-1:0] RST_SAMPLE_PERIOD = 31'd268435;
    localparam logic [CFG_VAL_W-1:0] RST_ANGLE_NOISE   = 31'd268435;
    localparam logic [CFG_VAL_W-1:0] RST_BIAS_NOISE    = 31'd805306;
    localparam logic [CFG_VAL_W-1:0] RST_MEASURE_NOISE = 31'd134217728;

    localparam logic signed [31:0] Q28_ONE = 32'sd268435456;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic signed [31:0] filtered_rate;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh00_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -40'sh00_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/akgf_chan_if.sv -----
// ----------------------------------------------------------------------------
// akgf_chan_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface akgf_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/akgf_gain_div.sv -----
// ----------------------------------------------------------------------------
// akgf_gain_div
// Two-lane restoring divider for the Kalman gains: k = (num << 28) / den,
// truncated toward zero, saturated to 32 bits, zero for a zero denominator.
// ----------------------------------------------------------------------------
module akgf_gain_div import akgf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num0,
    input  logic signed [31:0] i_num1,
    input  logic signed [32:0] i_den,
    output t_div_sts           o_sts,
    output logic signed [31:0] o_k0,
    output logic signed [31:0] o_k1
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_dstate;

    t_dstate            r_state;
    logic [4:0]         r_cnt;
    logic               r_done;
    logic               r_zero;
    logic [32:0]        r_dabs;
    logic [32:0]        r_rem [2];
    logic [30:0]        r_dvd [2];
    logic [30:0]        r_quo [2];
    logic               r_ovf [2];
    logic               r_neg [2];

    logic signed [31:0] num   [2];
    logic [31:0]        nabs  [2];
    logic               novf  [2];
    logic [32:0]        dabs;
    logic [33:0]        rem2  [2];
    logic               ge    [2];
    logic [32:0]        n_rem [2];
    logic signed [31:0] k     [2];

    assign num[0] = i_num0;
    assign num[1] = i_num1;
    assign dabs   = i_den[32] ? (~i_den + 33'd1) : i_den;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            nabs[l]  = num[l][31] ? (~num[l] + 32'd1) : num[l];
            novf[l]  = {4'b0, nabs[l]} >= {dabs, 3'b000};
            rem2[l]  = {r_rem[l], r_dvd[l][30]};
            ge[l]    = rem2[l] >= {1'b0, r_dabs};
            n_rem[l] = ge[l] ? 33'(rem2[l] - {1'b0, r_dabs}) : rem2[l][32:0];
            if (r_zero) begin
                k[l] = '0;
            end else if (r_ovf[l]) begin
                k[l] = r_neg[l] ? S32_MIN : S32_MAX;
            end else if (r_neg[l]) begin
                k[l] = -$signed({1'b0, r_quo[l]});
            end else begin
                k[l] = $signed({1'b0, r_quo[l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_zero  <= 1'b1;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_zero <= (dabs == '0);
                        if (dabs == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_cnt   <= 5'd30;
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_dabs <= dabs;
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= {4'b0, nabs[l][31:3]};
                r_dvd[l] <= {nabs[l][2:0], 28'b0};
                r_quo[l] <= '0;
                r_ovf[l] <= novf[l];
                r_neg[l] <= num[l][31] ^ i_den[32];
            end
        end else if (r_state == D_RUN) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= n_rem[l];
                r_dvd[l] <= {r_dvd[l][29:0], 1'b0};
                r_quo[l] <= {r_quo[l][29:0], ge[l]};
            end
        end
    end

    assign o_sts.busy = (r_state == D_RUN);
    assign o_sts.done = r_done;
    assign o_k0       = k[0];
    assign o_k1       = k[1];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == D_IDLE)
        else $error("divider started while busy");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == D_RUN) || $past(i_start))
        else $error("divider done without work");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == D_RUN && r_cnt != '0 |=> r_state == D_RUN)
        else $error("divider left run early");

endmodule

// ----- rtl/core/angle_gyro_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter
// Two-state angle / gyro-bias Kalman filter, one shared 33x33 multiplier and
// a two-lane serial gain divider under a small sequencer.
//
//  channel  dir  payload                               transaction when
//  i_in     in   measured_angle, measured_rate         valid & ready
//  o_out    out  filtered_angle, filtered_rate         valid & ready
//  i_cfg    in   index, value (31 bits, Q3.28)         valid & ready
//
// Each accepted transaction runs nine products through the shared multiplier,
// each in an S_MUL then an S_ACC state, and one pass of the gain divider,
// which retires one quotient bit per cycle for both gains.
// Synchronous active-low reset; control, config and filter state take defaults.
// i_in is ready only while the sequencer is idle; a pending result in the
// output register stalls only the final write-back step.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter import akgf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    akgf_chan_if.sink   i_in,
    akgf_chan_if.source o_out,
    akgf_chan_if.sink   i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [3:0] STEP_PRED = 4'd0;
    localparam logic [3:0] STEP_PAA  = 4'd1;
    localparam logic [3:0] STEP_PAB  = 4'd2;
    localparam logic [3:0] STEP_ANG  = 4'd3;
    localparam logic [3:0] STEP_BIAS = 4'd4;
    localparam logic [3:0] STEP_NAA  = 4'd5;
    localparam logic [3:0] STEP_NAB  = 4'd6;
    localparam logic [3:0] STEP_NBA  = 4'd7;
    localparam logic [3:0] STEP_NBB  = 4'd8;

    t_state             r_state;
    t_state             n_state;
    logic [3:0]         r_step;
    logic               r_div_start;

    logic [30:0]        r_sample_period;
    logic [30:0]        r_angle_noise;
    logic [30:0]        r_bias_noise;
    logic [30:0]        r_measure_noise;

    logic signed [31:0] r_est;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_cov_aa;
    logic signed [31:0] r_cov_ab;
    logic signed [31:0] r_cov_ba;
    logic signed [31:0] r_cov_bb;

    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic signed [31:0] r_innov;
    logic signed [31:0] r_p00;
    logic signed [31:0] r_p01;
    logic signed [31:0] r_p10;
    logic signed [31:0] r_p11;
    logic signed [31:0] r_rate;
    logic signed [65:0] r_prod;

    t_out_item          r_out;
    logic               r_out_valid;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] dt33;
    logic signed [65:0] prod_rnd;
    logic signed [39:0] rnd40;
    logic signed [32:0] den;
    logic               in_fire;
    logic               out_load;

    t_div_sts           div_sts;
    logic signed [31:0] k0;
    logic signed [31:0] k1;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign dt33     = $signed({2'b00, r_sample_period});
    assign prod_rnd = r_prod + 66'sh400_0000;
    assign rnd40    = 40'($signed(prod_rnd[65:28]));
    assign den      = 33'(r_p00) + $signed({2'b00, r_measure_noise});

    akgf_gain_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num0  (r_p00),
        .i_num1  (r_p10),
        .i_den   (den),
        .o_sts   (div_sts),
        .o_k0    (k0),
        .o_k1    (k1)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            STEP_PRED: begin
                mul_a = 33'(r_w) - 33'(r_bias);
                mul_b = dt33;
            end
            STEP_PAA: begin
                mul_a = 33'(r_cov_ab) + 33'(r_cov_ba);
                mul_b = dt33;
            end
            STEP_PAB: begin
                mul_a = 33'(r_cov_bb);
                mul_b = dt33;
            end
            STEP_ANG: begin
                mul_a = 33'(k0);
                mul_b = 33'(r_innov);
            end
            STEP_BIAS: begin
                mul_a = 33'(k1);
                mul_b = 33'(r_innov);
            end
            STEP_NAA: begin
                mul_a = 33'(k0);
                mul_b = 33'(r_p00);
            end
            STEP_NAB: begin
                mul_a = 33'(k0);
                mul_b = 33'(r_p01);
            end
            STEP_NBA: begin
                mul_a = 33'(k1);
                mul_b = 33'(r_p00);
            end
            STEP_NBB: begin
                mul_a = 33'(k1);
                mul_b = 33'(r_p01);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_fire) n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if (r_step == STEP_PAB) begin
                    n_state = S_DIV;
                end else if (r_step == STEP_NBB) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIV:  if (div_sts.done) n_state = S_MUL;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_step          <= STEP_PRED;
            r_div_start     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_sample_period <= RST_SAMPLE_PERIOD;
            r_angle_noise   <= RST_ANGLE_NOISE;
            r_bias_noise    <= RST_BIAS_NOISE;
            r_measure_noise <= RST_MEASURE_NOISE;
            r_est           <= '0;
            r_bias          <= '0;
            r_cov_aa        <= Q28_ONE;
            r_cov_ab        <= '0;
            r_cov_ba        <= '0;
            r_cov_bb        <= Q28_ONE;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == S_ACC) && (r_step == STEP_PAB);

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg.data.value;
                    CFG_ANGLE_NOISE:   r_angle_noise   <= i_cfg.data.value;
                    CFG_BIAS_NOISE:    r_bias_noise    <= i_cfg.data.value;
                    CFG_MEASURE_NOISE: r_measure_noise <= i_cfg.data.value;
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_step <= STEP_PRED;
            end
            if (r_state == S_DIV && div_sts.done) begin
                r_step <= STEP_ANG;
            end

            if (r_state == S_ACC) begin
                if (r_step != STEP_PAB && r_step != STEP_NBB) begin
                    r_step <= r_step + 4'd1;
                end
                case (r_step)
                    STEP_PRED: r_est    <= sat32(40'(r_est) + rnd40);
                    STEP_ANG:  r_est    <= sat32(40'(r_est) + rnd40);
                    STEP_BIAS: r_bias   <= sat32(40'(r_bias) + rnd40);
                    STEP_NAA:  r_cov_aa <= sat32(40'(r_p00) - rnd40);
                    STEP_NAB:  r_cov_ab <= sat32(40'(r_p01) - rnd40);
                    STEP_NBA:  r_cov_ba <= sat32(40'(r_p10) - rnd40);
                    STEP_NBB:  r_cov_bb <= sat32(40'(r_p11) - rnd40);
                    default: ;
                endcase
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_z <= i_in.data.measured_angle;
            r_w <= i_in.data.measured_rate;
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_ACC) begin
            case (r_step)
                STEP_PAA: begin
                    r_p00   <= sat32(40'(r_cov_aa) + $signed({9'b0, r_angle_noise}) - rnd40);
                    r_innov <= sat32(40'(r_z) - 40'(r_est));
                end
                STEP_PAB: begin
                    r_p01 <= sat32(40'(r_cov_ab) - rnd40);
                    r_p10 <= sat32(40'(r_cov_ba) - rnd40);
                    r_p11 <= sat32(40'(r_cov_bb) + $signed({9'b0, r_bias_noise}));
                end
                STEP_NAA: r_rate <= sat32(40'(r_w) - 40'(r_bias));
                default: ;
            endcase
        end
        if (out_load) begin
            r_out.filtered_angle <= r_est;
            r_out.filtered_rate  <= r_rate;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_MUL && r_step == STEP_PRED)
        else $error("accepted transaction did not start the sequence");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> r_state == S_DIV)
        else $error("gain divider finished outside its phase");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !div_sts.busy && !r_div_start)
        else $error("gain divider busy while idle");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result not presented");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_NBB)
        else $error("step counter out of range");

endmodule
